// ===== src/hts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_pkg: shared types and constants for the hall tachometer
// Holds the controller states, the command/status structs and the fixed-point
// scaling constants that are used by the datapath and the divider.
// ----------------------------------------------------------------------------
package hts_pkg;

    // timestamp and result widths
    localparam int TIME_W = 32;
    localparam int RES_W  = 32;
    localparam int DIAM_W = 16;

    // divider geometry: dividend holds the speed numerator, divisor holds 11 * period
    localparam int DVD_W     = 41;
    localparam int DSR_W     = TIME_W + 4;
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

    // 60e6 * 256, numerator of rpm in q8
    localparam logic [DVD_W-1:0] RPM_NUM_Q8 = 41'd15360000000;
    // 7500000 * pi (q20), multiplied by the diameter and shifted down by 20
    localparam int KSPD_W = 45;
    localparam logic [KSPD_W-1:0] SPEED_K = 45'd24706492500000;
    localparam int PROD_W = KSPD_W + DIAM_W;

    localparam logic [RES_W-1:0] SAT32 = '1;

    // configuration register indexes
    localparam logic CFG_ENABLE   = 1'b0;
    localparam logic CFG_DIAMETER = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_START,
        S_WAIT,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;       // input transaction accepted
        logic eval;       // evaluate special cases, register operands
        logic div_start;  // launch both dividers
        logic save;       // capture divider quotients
        logic load_out;   // move result into the output register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_dp_status;

    // clamp a wide quotient to 32 bits
    function automatic logic [RES_W-1:0] sat32(input logic [DVD_W-1:0] q);
        logic [RES_W-1:0] r;
        if (q[DVD_W-1:RES_W] != '0) begin
            r = SAT32;
        end else begin
            r = q[RES_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/hts_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_divider: iterative restoring divider
// One quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module hts_divider
    import hts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DSR_W-1:0]     r_rem, n_rem;
    logic [DVD_W-1:0]     r_quo, n_quo;
    logic [DSR_W-1:0]     r_dvsr, n_dvsr;
    logic [DSR_W:0]       shifted;
    logic [DSR_W:0]       diff;

    // one restoring step
    assign shifted = {r_rem, r_quo[DVD_W-1]};
    assign diff    = shifted - {1'b0, r_dvsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvsr = r_dvsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvsr = i_divisor;
        end else if (r_busy) begin
            if (!diff[DSR_W]) begin
                n_rem = diff[DSR_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DSR_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dvsr <= n_dvsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (r_dvsr != '0) |-> r_rem < r_dvsr)
        else $error("divider remainder out of range");

    // a new division is never launched over a running one
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

// ===== src/hts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_datapath: edge tracking, scaling and result registers
// Holds configuration, the falling-edge timestamps, the speed numerator
// multiply, two dividers for rpm and speed, and the output register.
// ----------------------------------------------------------------------------
module hts_datapath
    import hts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [DIAM_W-1:0] i_cfg_data,
    input  logic              i_pin_level,
    input  logic [TIME_W-1:0] i_timestamp_us,
    input  t_ctrl_cmd         i_cmd,
    output t_dp_status        o_status,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_revolution_done,
    output logic [RES_W-1:0]  o_rpm_q8,
    output logic [RES_W-1:0]  o_speed_mph_q8
);

    logic              r_enable;
    logic [DIAM_W-1:0] r_diameter;
    logic              r_high_seen;
    logic [TIME_W-1:0] r_prev_time;
    logic [TIME_W-1:0] r_last_time;
    logic [1:0]        r_edges;
    logic              r_done;
    logic [DVD_W-1:0]  r_num;
    logic [DSR_W-1:0]  r_spd_div;
    logic [RES_W-1:0]  r_rpm;
    logic [RES_W-1:0]  r_spd;
    logic              r_out_valid;
    logic              r_out_done;
    logic [RES_W-1:0]  r_out_rpm;
    logic [RES_W-1:0]  r_out_spd;

    logic [TIME_W-1:0] period;
    logic              results_on;
    logic              period_zero;
    logic [PROD_W-1:0] product;
    logic [DSR_W-1:0]  spd_div;
    logic              rpm_done, spd_done;
    logic [DVD_W-1:0]  rpm_quo, spd_quo;

    // period and operands
    assign period      = r_last_time - r_prev_time;
    assign period_zero = (period == '0);
    assign results_on  = r_enable && r_edges[1];
    assign product     = PROD_W'(r_diameter) * PROD_W'(SPEED_K);
    assign spd_div     = {4'b0, period} + {1'b0, period, 3'b0} + {3'b0, period, 1'b0};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_diameter <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                CFG_DIAMETER: r_diameter <= i_cfg_data;
                default:      r_enable   <= r_enable;
            endcase
        end
    end

    // falling edge detection on each accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_seen <= 1'b0;
            r_prev_time <= '0;
            r_last_time <= '0;
            r_edges     <= '0;
            r_done      <= 1'b0;
        end else if (i_cmd.take) begin
            r_done <= 1'b0;
            if (r_enable) begin
                if (i_pin_level) begin
                    r_high_seen <= 1'b1;
                end else if (r_high_seen) begin
                    r_prev_time <= r_last_time;
                    r_last_time <= i_timestamp_us;
                    r_high_seen <= 1'b0;
                    r_done      <= 1'b1;
                    if (!r_edges[1]) begin
                        r_edges <= r_edges + 2'd1;
                    end
                end
            end
        end
    end

    // special cases and division operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_num     <= product[PROD_W-1:PROD_W-DVD_W];
            r_spd_div <= spd_div;
            if (!results_on) begin
                r_rpm <= '0;
                r_spd <= '0;
            end else begin
                r_rpm <= SAT32;
                r_spd <= (r_diameter != '0) ? SAT32 : '0;
            end
        end else if (i_cmd.save) begin
            r_rpm <= sat32(rpm_quo);
            r_spd <= sat32(spd_quo);
        end
    end

    // rpm = 60e6 * 256 / period
    hts_divider u_div_rpm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (RPM_NUM_Q8),
        .i_divisor  ({4'b0, period}),
        .o_done     (rpm_done),
        .o_quotient (rpm_quo)
    );

    // speed = numerator / (11 * period)
    hts_divider u_div_spd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_num),
        .i_divisor  (r_spd_div),
        .o_done     (spd_done),
        .o_quotient (spd_quo)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_done <= r_done;
            r_out_rpm  <= r_rpm;
            r_out_spd  <= r_spd;
        end
    end

    assign o_status.need_div = results_on && !period_zero;
    assign o_status.div_done = rpm_done;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_revolution_done = r_out_done;
    assign o_rpm_q8          = r_out_rpm;
    assign o_speed_mph_q8    = r_out_spd;

    // both dividers run the same step count and finish together
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rpm_done == spd_done)
        else $error("rpm and speed dividers out of step");

    // edge counter saturates at two
    a_edges_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edges != 2'd3)
        else $error("edge counter overflow");

endmodule

// ===== src/hts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_ctrl: sequencing state machine
// Takes one sample, evaluates it, runs the dividers when a nonzero period is known
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module hts_ctrl
    import hts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_in_stall
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.need_div ? S_START : S_DONE;
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.save = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // result only moves into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free)
        else $error("output register overwritten");

    // launching the dividers always leads to the wait state
    a_start_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == S_WAIT)
        else $error("divider launch without wait");

endmodule

// ===== src/hall_tachometer_speed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_tachometer_speed: period-measuring tachometer for a hall sensor
// Detects falling edges after a high level, measures the edge-to-edge period
// and reports rpm and wheel speed in mph, both unsigned q8 and saturated.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   i_pin_level, i_timestamp_us
//   output   out        o_out_valid / i_out_stall o_revolution_done, o_rpm_q8,
//                                                 o_speed_mph_q8
//   config   in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A sample that yields rpm and speed from a known nonzero period waits on
// the two 41-step restoring dividers running side by side; other samples
// skip the dividers. One transaction is in work at a time.
// The output register lets a new sample in while a result waits on a stall.
// Synchronous active-low reset clears configuration and edge history.
// ----------------------------------------------------------------------------
module hall_tachometer_speed
    import hts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [DIAM_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_pin_level,
    input  logic [TIME_W-1:0] i_timestamp_us,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_revolution_done,
    output logic [RES_W-1:0]  o_rpm_q8,
    output logic [RES_W-1:0]  o_speed_mph_q8
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // sequencing
    hts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // arithmetic and storage
    hts_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_pin_level       (i_pin_level),
        .i_timestamp_us    (i_timestamp_us),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_revolution_done (o_revolution_done),
        .o_rpm_q8          (o_rpm_q8),
        .o_speed_mph_q8    (o_speed_mph_q8)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for hall_tachometer_speed
// Drives hall pin samples with microsecond timestamps, keeps its own tachometer
// state to predict revolution flags, rpm and mph per sample, and compares each
// output transaction in order. Directed cases cover the disabled block, edge
// arming, zero, minimum and maximum periods, timestamp wrap and diameter
// extremes. They are followed by back-pressure and randomized pulse trains
// under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int           HALF_PERIOD   = 5;
    localparam int           SETTLE_CYCLES = 60;
    localparam int           HOLD_CYCLES   = 300;
    localparam int           WATCHDOG_MAX  = 4000;
    localparam int           SEG_ITEMS     = 80;
    localparam logic [63:0]  K_RPM_Q8      = 64'd15360000000;
    localparam logic [63:0]  K_SPEED       = 64'd7500000;
    localparam logic [63:0]  K_PI_Q20      = 64'd3294199;
    localparam logic [63:0]  K_MILE_DIV    = 64'd11;
    localparam logic [31:0]  RES_MAX       = hts_pkg::SAT32;

    typedef struct packed {
        logic        done;
        logic [31:0] rpm;
        logic [31:0] mph;
    } t_tach_result;

    // dut ports
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_cfg_we       = 1'b0;
    logic                          i_cfg_idx      = hts_pkg::CFG_ENABLE;
    logic [hts_pkg::DIAM_W-1:0]    i_cfg_data     = '0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_stall;
    logic                          i_pin_level    = 1'b0;
    logic [hts_pkg::TIME_W-1:0]    i_timestamp_us = '0;
    logic                          o_out_valid;
    logic                          i_out_stall    = 1'b0;
    logic                          o_revolution_done;
    logic [hts_pkg::RES_W-1:0]     o_rpm_q8;
    logic [hts_pkg::RES_W-1:0]     o_speed_mph_q8;

    // predicted tachometer state and configuration
    logic         cfg_enable   = 1'b0;
    logic [15:0]  cfg_diameter = '0;
    logic         arm_high     = 1'b0;
    logic [31:0]  edge_prev_us = '0;
    logic [31:0]  edge_last_us = '0;
    logic [1:0]   edge_count   = '0;

    t_tach_result tach_results_q[$];
    t_tach_result want_r;

    // stimulus control and statistics
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    bit           hold_req      = 1'b0;
    int           hold_left     = 0;
    logic [31:0]  tacho_now_us  = '0;
    int           n_samples     = 0;
    int           n_checked     = 0;
    int           n_revs        = 0;
    int           n_rpm_sat     = 0;
    int           n_mismatch    = 0;

    hall_tachometer_speed dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pin_level       (i_pin_level),
        .i_timestamp_us    (i_timestamp_us),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_revolution_done (o_revolution_done),
        .o_rpm_q8          (o_rpm_q8),
        .o_speed_mph_q8    (o_speed_mph_q8)
    );

    // clock
    always #HALF_PERIOD i_clk = ~i_clk;

    // tachometer prediction for one accepted sample
    task automatic predict_tach(input logic lvl, input logic [31:0] ts);
        t_tach_result r;
        logic [31:0]  period;
        logic [63:0]  spd_num;
        logic [63:0]  q;
        r = '0;
        if (cfg_enable) begin
            if (lvl) begin
                arm_high = 1'b1;
            end else if (arm_high) begin
                edge_prev_us = edge_last_us;
                edge_last_us = ts;
                arm_high     = 1'b0;
                if (edge_count < 2'd2) edge_count++;
                r.done = 1'b1;
                n_revs++;
            end
            if (edge_count == 2'd2) begin
                period = edge_last_us - edge_prev_us;
                if (period == '0) begin
                    r.rpm = RES_MAX;
                    r.mph = (cfg_diameter != '0) ? RES_MAX : '0;
                end else begin
                    spd_num = (K_SPEED * 64'(cfg_diameter) * K_PI_Q20) >> 20;
                    q       = K_RPM_Q8 / 64'(period);
                    r.rpm   = (q > 64'(RES_MAX)) ? RES_MAX : q[31:0];
                    q       = (spd_num / K_MILE_DIV) / 64'(period);
                    r.mph   = (q > 64'(RES_MAX)) ? RES_MAX : q[31:0];
                end
                if (r.rpm == RES_MAX) n_rpm_sat++;
            end
        end
        tach_results_q.push_back(r);
    endtask

    // offer one sample, optionally after a random gap, and wait for acceptance
    task automatic send_sample(input logic lvl, input logic [31:0] ts);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_pin_level    <= lvl;
        i_timestamp_us <= ts;
        do @(posedge i_clk); while (o_in_stall);
        n_samples++;
        predict_tach(lvl, ts);
    endtask

    // random time step between samples, mostly moderate, sometimes tiny or huge
    function automatic logic [31:0] pulse_step();
        logic [31:0] s;
        if ($urandom_range(15) == 0) begin
            s = $urandom;
        end else begin
            s = $urandom >> $urandom_range(31, 8);
        end
        return s;
    endfunction

    // a well-formed revolution: some high samples then some low samples
    task automatic send_revolution();
        int n_hi;
        int n_lo;
        n_hi = $urandom_range(3, 1);
        n_lo = $urandom_range(3, 1);
        repeat (n_hi) begin
            send_sample(1'b1, tacho_now_us);
            tacho_now_us += pulse_step();
        end
        repeat (n_lo) begin
            send_sample(1'b0, tacho_now_us);
            tacho_now_us += pulse_step();
        end
    endtask

    // stop offering and wait until every predicted result has been checked
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tach_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both registers back to back, only while the block is idle
    task automatic write_config(input logic en, input logic [15:0] diam);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= hts_pkg::CFG_ENABLE;
        i_cfg_data <= {15'd0, en};
        @(posedge i_clk);
        cfg_enable = en;
        i_cfg_idx  <= hts_pkg::CFG_DIAMETER;
        i_cfg_data <= diam;
        @(posedge i_clk);
        cfg_diameter = diam;
        i_cfg_we   <= 1'b0;
    endtask

    // disabled after reset: edges are ignored and results are zero
    task automatic test_disabled_at_reset();
        send_sample(1'b1, 32'd5);
        send_sample(1'b0, 32'd6);
        drain_results();
    endtask

    // edge arming, repeated levels, first edge, period extremes and wrap
    task automatic test_edge_cases();
        write_config(1'b1, 16'h0180);
        send_sample(1'b0, 32'd0);
        send_sample(1'b1, 32'd10);
        send_sample(1'b1, 32'd20);
        send_sample(1'b0, 32'd100);
        send_sample(1'b0, 32'd120);
        // nominal period
        send_sample(1'b1, 32'd200);
        send_sample(1'b0, 32'd16767);
        // zero period
        send_sample(1'b1, 32'd16767);
        send_sample(1'b0, 32'd16767);
        // period of one microsecond
        send_sample(1'b1, 32'd16767);
        send_sample(1'b0, 32'd16768);
        // timestamp wraps, long period
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'd5);
        // largest period
        send_sample(1'b1, 32'd0);
        send_sample(1'b0, 32'd4);
        drain_results();
    endtask

    // zero and full-scale wheel diameter
    task automatic test_diameter_extremes();
        write_config(1'b1, 16'h0000);
        send_sample(1'b1, 32'd4);
        send_sample(1'b0, 32'd4);
        drain_results();
        write_config(1'b1, 16'hFFFF);
        send_sample(1'b1, 32'd4);
        send_sample(1'b0, 32'd5);
        send_sample(1'b1, 32'd1000);
        send_sample(1'b0, 32'd3005);
        drain_results();
    endtask

    // state survives a disable and re-enable
    task automatic test_disable_keeps_state();
        write_config(1'b0, 16'h0200);
        send_sample(1'b1, 32'd4000);
        send_sample(1'b0, 32'd5000);
        drain_results();
        write_config(1'b1, 16'h0200);
        send_sample(1'b1, 32'd6000);
        send_sample(1'b0, 32'd9005);
        drain_results();
    endtask

    // receiver holds off while samples keep coming, then sender waits for all
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_config(1'b1, 16'h0140);
        hold_req = 1'b1;
        repeat (15) send_revolution();
        drain_results();
    endtask

    // randomized pulse trains with some noise, several settings per phase
    task automatic test_random_phase(input int idle_p, input int stall_p);
        int    seg_base;
        int    seg_items;
        logic  en;
        logic [15:0] diam;
        send_idle_pct = idle_p;
        stall_pct     = stall_p;
        repeat (3) begin
            en = ($urandom_range(5) != 0);
            case ($urandom_range(3))
                0:       diam = 16'h0000;
                1:       diam = 16'hFFFF;
                default: diam = 16'($urandom);
            endcase
            write_config(en, diam);
            seg_items = en ? SEG_ITEMS : 15;
            seg_base  = n_samples;
            while (n_samples - seg_base < seg_items) begin
                if ($urandom_range(9) == 0) begin
                    send_sample(1'($urandom_range(1)), $urandom);
                end else begin
                    send_revolution();
                end
            end
            drain_results();
        end
    endtask

    // receiver stall: random, or a long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_checked++;
            if (tach_results_q.size() == 0) begin
                $error("unexpected result: done=%0d rpm=%0d mph=%0d",
                       o_revolution_done, o_rpm_q8, o_speed_mph_q8);
                n_mismatch++;
            end else begin
                want_r = tach_results_q.pop_front();
                if (o_revolution_done !== want_r.done) begin
                    $error("revolution_done: expected %0d, actual %0d",
                           want_r.done, o_revolution_done);
                    n_mismatch++;
                end
                if (o_rpm_q8 !== want_r.rpm) begin
                    $error("rpm_q8: expected %0d, actual %0d", want_r.rpm, o_rpm_q8);
                    n_mismatch++;
                end
                if (o_speed_mph_q8 !== want_r.mph) begin
                    $error("speed_mph_q8: expected %0d, actual %0d",
                           want_r.mph, o_speed_mph_q8);
                    n_mismatch++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_MAX) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout after %0d quiet cycles", WATCHDOG_MAX);
        $display("FAILED: results differ");
        $finish;
    end

    // test sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_at_reset();
        test_edge_cases();
        test_diameter_extremes();
        test_disable_keeps_state();
        test_backpressure();
        test_random_phase(0, 0);
        test_random_phase(84, 0);
        test_random_phase(0, 84);
        test_random_phase(19, 19);
        drain_results();
        $display("run covered %0d samples and %0d checked results", n_samples, n_checked);
        $display("%0d revolutions, %0d saturated rpm values", n_revs, n_rpm_sat);
        if (n_mismatch == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
